>>> rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

    localparam int POS_W      = 24;
    localparam int COORD_W    = 12;
    localparam int FRAC_W     = 8;
    localparam int FACT_W     = 16;
    localparam int CNT_CFG_W  = 5;
    localparam int OUT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = DIFF_W + FACT_W + 1;
    localparam int RND_SHIFT  = 16;
    localparam int RND_W      = PROD_W - RND_SHIFT;
    localparam int SUM_W      = RND_W + 1;

    localparam int DEF_MAX_VERTICES = 16;

    localparam logic [CNT_CFG_W-1:0] RST_VERTEX_COUNT = 5'd16;
    localparam logic [FACT_W-1:0]    RST_EASE         = 16'd13107;
    localparam logic [FACT_W-1:0]    RST_DAMP         = 16'd52429;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP         = 2'd2;

    // command codes
    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_INIT = 1'b1;

    localparam logic signed [SUM_W-1:0] SAT_HI = 27'sd8388607;
    localparam logic signed [SUM_W-1:0] SAT_LO = -27'sd8388608;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } cmd_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
    } entry_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INIT = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_MDX  = 8'b0000_1000,
        S_MDY  = 8'b0001_0000,
        S_MVX  = 8'b0010_0000,
        S_MVY  = 8'b0100_0000,
        S_WB   = 8'b1000_0000
    } state_t;

    // clamp a widened sum to the signed 24-bit range
    function automatic logic signed [POS_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[POS_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[POS_W-1:0];
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] add_sat(input logic signed [POS_W-1:0] a,
                                                        input logic signed [RND_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return sat24(s);
    endfunction

endpackage

`default_nettype wire

>>> rtl/sfc_chan_if.sv
`default_nettype none

interface sfc_chan_if #(parameter type data_t = logic) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/spring_follower_chain.sv
`default_nettype none

// Chain of damped spring followers, positions and velocities in signed Q15.8.
// A step command pulls vertex 0 toward the target and each later vertex toward
// the position just given to its predecessor; an init command places every
// vertex at the point with zero velocity. Each command returns one res word per
// vertex in use, vertex 0 first, with last set on the final word. In a step
// every vertex in use costs one state memory read and four products on the
// single shared multiplier (two ease, two damping), the write-back state also
// writing the vertex back and loading the result. An init needs no clearing
// pass: it drops the per-vertex valid bits and records the point, and a vertex
// without its valid bit reads as that point at rest. cmd is not ready while a
// command is at work; res backpressure stalls the sequencer. Write cfg only
// while idle.
module spring_follower_chain #(
    parameter int MAX_VERTICES = sfc_pkg::DEF_MAX_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    sfc_chan_if.sink    cfg,
    sfc_chan_if.sink    cmd,
    sfc_chan_if.source  res
);
    import sfc_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // configuration registers
    logic [CNT_CFG_W-1:0] vertex_count_reg;
    logic [FACT_W-1:0]    ease_reg;
    logic [FACT_W-1:0]    damp_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]  cfg_last_idx;

    // init point and per-vertex valid bits
    logic [COORD_W-1:0]      init_x_reg, init_x_next;
    logic [COORD_W-1:0]      init_y_reg, init_y_next;
    logic [MAX_VERTICES-1:0] valid_reg, valid_next;

    // working vertex and leader
    logic signed [POS_W-1:0] px_reg, px_next;
    logic signed [POS_W-1:0] py_reg, py_next;
    logic signed [POS_W-1:0] vx_reg, vx_next;
    logic signed [POS_W-1:0] vy_reg, vy_next;
    logic signed [POS_W-1:0] lx_reg, lx_next;
    logic signed [POS_W-1:0] ly_reg, ly_next;
    logic signed [POS_W-1:0] vy_fin;

    // state memory
    entry_t mem [MAX_VERTICES];
    entry_t mem_rd_reg;
    entry_t init_entry;
    entry_t cur_entry;
    entry_t wr_entry;
    logic   mem_we;

    // shared multiplier
    logic                     mul_en;
    logic signed [DIFF_W-1:0] mul_a;
    logic [FACT_W-1:0]        mul_f;
    logic signed [RND_W-1:0]  mul_rnd;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic signed [POS_W-1:0] out_x_reg, out_x_next;
    logic signed [POS_W-1:0] out_y_reg, out_y_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_free;
    logic                    out_load;

    logic cmd_fire;
    cmd_t cmd_word;
    cfg_t cfg_word;

    assign cmd_word  = cmd.data;
    assign cfg_word  = cfg.data;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign out_free  = !out_valid_reg || res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = '{vertex_index: out_idx_reg, pos_x: out_x_reg,
                         pos_y: out_y_reg, last: out_last_reg};

    // ---------------------------------------------------------------
    // Configuration: unknown indexes drop the word
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= RST_VERTEX_COUNT;
            ease_reg         <= RST_EASE;
            damp_reg         <= RST_DAMP;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_word.index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_word.value[CNT_CFG_W-1:0];
                CFG_EASE:         ease_reg         <= cfg_word.value[FACT_W-1:0];
                CFG_DAMP:         damp_reg         <= cfg_word.value[FACT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the vertex count to 1..MAX_VERTICES and hold it as the last index
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            cfg_last_idx = '0;
        end
        else if (int'(vertex_count_reg) > MAX_VERTICES)
        begin
            cfg_last_idx = IDX_W'(MAX_VERTICES - 1);
        end
        else
        begin
            cfg_last_idx = IDX_W'(vertex_count_reg - 1'b1);
        end
    end

    // ---------------------------------------------------------------
    // State memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_entry;
        end
        mem_rd_reg <= mem[idx_reg];
    end

    // A vertex not written since the last init sits at the init point at rest
    assign init_entry = '{pos_x: POS_W'({init_x_reg, FRAC_W'(0)}),
                          pos_y: POS_W'({init_y_reg, FRAC_W'(0)}),
                          vel_x: '0, vel_y: '0};
    assign cur_entry  = valid_reg[idx_reg] ? mem_rd_reg : init_entry;

    // Final damped velocity comes straight off the multiplier in write-back
    assign vy_fin   = sat24(SUM_W'(mul_rnd));
    assign wr_entry = '{pos_x: px_reg, pos_y: py_reg, vel_x: vx_reg, vel_y: vy_fin};

    // ---------------------------------------------------------------
    // Shared multiplier operand select
    // ---------------------------------------------------------------
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_f  = ease_reg;
        unique case (state_reg)
            S_MDX:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(lx_reg) - DIFF_W'(cur_entry.pos_x);
            end
            S_MDY:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(ly_reg) - DIFF_W'(py_reg);
            end
            S_MVX:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(vx_reg);
                mul_f  = damp_reg;
            end
            S_MVY:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(vy_reg);
                mul_f  = damp_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    sfc_mul_unit u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .f   (mul_f),
        .rnd (mul_rnd)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        init_x_next    = init_x_reg;
        init_y_next    = init_y_reg;
        valid_next     = valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        out_idx_next   = out_idx_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    idx_next      = '0;
                    last_idx_next = cfg_last_idx;
                    lx_next       = POS_W'({cmd_word.target_x, FRAC_W'(0)});
                    ly_next       = POS_W'({cmd_word.target_y, FRAC_W'(0)});
                    if (cmd_word.func == FUNC_INIT)
                    begin
                        init_x_next = cmd_word.target_x;
                        init_y_next = cmd_word.target_y;
                        valid_next  = '0;
                        state_next  = S_INIT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_INIT:
            begin
                // every vertex reads as the init point; just emit them
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_idx_next  = OUT_IDX_W'(idx_reg);
                    out_x_next    = init_entry.pos_x;
                    out_y_next    = init_entry.pos_y;
                    out_last_next = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MDX;
            end
            S_MDX:
            begin
                px_next    = cur_entry.pos_x;
                py_next    = cur_entry.pos_y;
                vx_next    = cur_entry.vel_x;
                vy_next    = cur_entry.vel_y;
                state_next = S_MDY;
            end
            S_MDY:
            begin
                vx_next    = add_sat(vx_reg, mul_rnd);
                state_next = S_MVX;
            end
            S_MVX:
            begin
                vy_next    = add_sat(vy_reg, mul_rnd);
                px_next    = add_sat(px_reg, RND_W'(vx_reg));
                state_next = S_MVY;
            end
            S_MVY:
            begin
                vx_next    = sat24(SUM_W'(mul_rnd));
                py_next    = add_sat(py_reg, RND_W'(vy_reg));
                state_next = S_WB;
            end
            S_WB:
            begin
                // hold here while the result slot is full
                if (out_free)
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    vy_next             = vy_fin;
                    lx_next             = px_reg;
                    ly_next             = py_reg;
                    out_load            = 1'b1;
                    out_idx_next        = OUT_IDX_W'(idx_reg);
                    out_x_next          = px_reg;
                    out_y_next          = py_reg;
                    out_last_next       = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            init_x_reg    <= '0;
            init_y_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            init_x_reg    <= init_x_next;
            init_y_reg    <= init_y_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        out_idx_reg  <= out_idx_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd.ready)
        else $error("cmd still ready after a command was taken");

    a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (idx_reg == '0))
        else $error("vertex index not rewound when idle");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (idx_reg <= last_idx_reg))
        else $error("state memory written beyond the vertices in use");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (out_last_reg == (state_reg == S_IDLE))))
        else $error("loaded result missing or last flag out of step with sequencer");

endmodule

`default_nettype wire

>>> rtl/sfc_mul_unit.sv
`default_nettype none

module sfc_mul_unit (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [sfc_pkg::DIFF_W-1:0]  a,
    input  logic        [sfc_pkg::FACT_W-1:0]  f,
    output logic signed [sfc_pkg::RND_W-1:0]   rnd
);
    import sfc_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 42'sd32768;

    logic signed [PROD_W-1:0] prod;
    logic signed [RND_W-1:0]  rnd_reg;

    // Q0.16 product, round to nearest with ties up, then drop the fraction
    assign prod = PROD_W'(a) * $signed({1'b0, f}) + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= prod[PROD_W-1:RND_SHIFT];
        end
    end

    assign rnd = rnd_reg;

endmodule

`default_nettype wire

>>> tb/sv/chain_position_checker.sv
`default_nettype none

module chain_position_checker
    import sfc_pkg::*;
#(
    parameter int VERTICES = DEF_MAX_VERTICES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  cfg_t cfg_data,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd_data,
    input  logic res_valid,
    input  logic res_ready,
    input  res_t res_data,
    output int   mismatch_count,
    output int   pending_positions
);

    localparam longint POS_HI    = 64'sd8388607;
    localparam longint POS_LO    = -64'sd8388608;
    localparam longint ROUND_BIT = 64'sd32768;
    localparam int     PRINT_CAP = 40;

    logic [CNT_CFG_W-1:0] count_reg;
    logic [FACT_W-1:0]    ease_reg;
    logic [FACT_W-1:0]    damp_reg;

    logic signed [POS_W-1:0] chain_px [VERTICES];
    logic signed [POS_W-1:0] chain_py [VERTICES];
    logic signed [POS_W-1:0] chain_vx [VERTICES];
    logic signed [POS_W-1:0] chain_vy [VERTICES];

    res_t expected_positions [$];

    task automatic report_mismatch(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    function automatic longint clamp_q15_8(input longint v);
        if (v > POS_HI)
        begin
            return POS_HI;
        end
        if (v < POS_LO)
        begin
            return POS_LO;
        end
        return v;
    endfunction

    // product with a Q0.16 factor, rounded to nearest with ties toward +inf
    function automatic longint scale_q16(input longint a, input logic [FACT_W-1:0] f);
        longint p;
        p = a * longint'(f) + ROUND_BIT;
        return p >>> RND_SHIFT;
    endfunction

    function automatic void pull_axis(inout logic signed [POS_W-1:0] pos,
                                      inout logic signed [POS_W-1:0] vel,
                                      input longint leader);
        longint gap;
        longint v_sat;
        gap   = leader - longint'(pos);
        v_sat = clamp_q15_8(longint'(vel) + scale_q16(gap, ease_reg));
        pos   = POS_W'(clamp_q15_8(longint'(pos) + v_sat));
        vel   = POS_W'(clamp_q15_8(scale_q16(v_sat, damp_reg)));
    endfunction

    task automatic apply_setting(input cfg_t w);
        case (w.index)
            CFG_VERTEX_COUNT: count_reg = w.value[CNT_CFG_W-1:0];
            CFG_EASE:         ease_reg  = w.value[FACT_W-1:0];
            CFG_DAMP:         damp_reg  = w.value[FACT_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic predict_positions(input cmd_t c);
        int                      n;
        int                      i;
        longint                  tx;
        longint                  ty;
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] v;
        res_t                    r;
        if (count_reg == 0)
        begin
            n = 1;
        end
        else if (count_reg > VERTICES)
        begin
            n = VERTICES;
        end
        else
        begin
            n = int'(count_reg);
        end
        tx = longint'(c.target_x) << FRAC_W;
        ty = longint'(c.target_y) << FRAC_W;
        if (c.func == FUNC_INIT)
        begin
            for (i = 0; i < VERTICES; i++)
            begin
                chain_px[i] = POS_W'(tx);
                chain_py[i] = POS_W'(ty);
                chain_vx[i] = '0;
                chain_vy[i] = '0;
            end
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                p = chain_px[i];
                v = chain_vx[i];
                pull_axis(p, v, (i == 0) ? tx : longint'(chain_px[i-1]));
                chain_px[i] = p;
                chain_vx[i] = v;
                p = chain_py[i];
                v = chain_vy[i];
                pull_axis(p, v, (i == 0) ? ty : longint'(chain_py[i-1]));
                chain_py[i] = p;
                chain_vy[i] = v;
            end
        end
        for (i = 0; i < n; i++)
        begin
            r.vertex_index = OUT_IDX_W'(i);
            r.pos_x        = chain_px[i];
            r.pos_y        = chain_py[i];
            r.last         = (i == n - 1);
            expected_positions = {expected_positions, r};
        end
    endtask

    task automatic check_position(input res_t got);
        res_t want;
        if (expected_positions.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word for vertex %0d", got.vertex_index));
            return;
        end
        want = expected_positions.pop_front();
        if (got.vertex_index !== want.vertex_index)
        begin
            report_mismatch($sformatf("vertex_index got %0d expected %0d",
                                      got.vertex_index, want.vertex_index));
        end
        if (got.pos_x !== want.pos_x)
        begin
            report_mismatch($sformatf("vertex %0d pos_x got %0d expected %0d",
                                      want.vertex_index, got.pos_x, want.pos_x));
        end
        if (got.pos_y !== want.pos_y)
        begin
            report_mismatch($sformatf("vertex %0d pos_y got %0d expected %0d",
                                      want.vertex_index, got.pos_y, want.pos_y));
        end
        if (got.last !== want.last)
        begin
            report_mismatch($sformatf("vertex %0d last got %0b expected %0b",
                                      want.vertex_index, got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = RST_VERTEX_COUNT;
            ease_reg  = RST_EASE;
            damp_reg  = RST_DAMP;
            for (int i = 0; i < VERTICES; i++)
            begin
                chain_px[i] = '0;
                chain_py[i] = '0;
                chain_vx[i] = '0;
                chain_vy[i] = '0;
            end
            expected_positions.delete();
            mismatch_count = 0;
            pending_positions <= 0;
        end
        else
        begin
            // retire results before queuing new ones so a stray word is caught
            if (res_valid && res_ready)
            begin
                check_position(res_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_data);
            end
            if (cmd_valid && cmd_ready)
            begin
                predict_positions(cmd_data);
            end
            pending_positions <= expected_positions.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/spring_follower_chain_test.sv
`default_nettype none

module spring_follower_chain_test;
    import sfc_pkg::*;

    // slowest run: ~182 commands of up to 16 words each, every word open to a
    // result stall and every command to a sender gap; keep several times that
    localparam int LIMIT_CYCLES  = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 26;
    localparam int END_PAUSE     = 100;
    localparam int CFG_PAUSE     = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [COORD_W-1:0]   COORD_MAX  = 12'hFFF;
    localparam logic [COORD_W-1:0]   COORD_MIN  = 12'h000;

    logic clk = 1'b0;
    logic rst_n;
    bit   allow_gaps;
    int   cycle_count;
    int   mismatch_count;
    int   pending_positions;

    sfc_chan_if #(.data_t(cfg_t)) cfg_ch ();
    sfc_chan_if #(.data_t(cmd_t)) cmd_ch ();
    sfc_chan_if #(.data_t(res_t)) res_ch ();

    always #5 clk = ~clk;

    spring_follower_chain dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    chain_position_checker position_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_ch.valid),
        .cfg_ready         (cfg_ch.ready),
        .cfg_data          (cfg_ch.data),
        .cmd_valid         (cmd_ch.valid),
        .cmd_ready         (cmd_ch.ready),
        .cmd_data          (cmd_ch.data),
        .res_valid         (res_ch.valid),
        .res_ready         (res_ch.ready),
        .res_data          (res_ch.data),
        .mismatch_count    (mismatch_count),
        .pending_positions (pending_positions)
    );

    // Send one command word. Valid stays high from the previous word unless a
    // gap is taken, so a back-to-back word only swaps the payload. Returns at
    // the edge that accepted the word.
    task automatic send_command(input logic func, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        cmd_t c;
        c.func     = func;
        c.target_x = x;
        c.target_y = y;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            // drop valid for a burst of random length
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Drop command valid and hold until every expected word has come back,
    // then let the sequencer wind down for the given pause.
    task automatic settle_chain(input int pause_cycles);
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_positions != 0);
        repeat (pause_cycles) @(posedge clk);
    endtask

    // Write all three registers back to back, optionally poking the unused
    // index in between; the block must ignore that write.
    task automatic program_settings(input logic [CFG_DATA_W-1:0] count_word,
                                    input logic [CFG_DATA_W-1:0] ease_word,
                                    input logic [CFG_DATA_W-1:0] damp_word,
                                    input bit poke_unused);
        cfg_t words [4];
        int   total;
        int   k;
        words[0] = '{index: CFG_VERTEX_COUNT, value: count_word};
        words[1] = '{index: CFG_EASE,         value: ease_word};
        words[2] = '{index: CFG_UNUSED,       value: CFG_DATA_W'($urandom)};
        words[3] = '{index: CFG_DAMP,         value: damp_word};
        if (!poke_unused)
        begin
            words[2] = words[3];
        end
        total = poke_unused ? 4 : 3;
        for (k = 0; k < total; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= words[k];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        end
        return COORD_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [FACT_W-1:0] pick_factor();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FACT_W'($urandom);
        endcase
    endfunction

    // Result-side backpressure: stall in random bursts while gaps are allowed,
    // otherwise keep ready high.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (allow_gaps && stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (allow_gaps && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                   phase;
        int                   k;
        bit                   square_wave;
        logic [CNT_CFG_W-1:0] cnt;
        logic [10:0]          upper;
        logic [FACT_W-1:0]    ease_word;
        logic [FACT_W-1:0]    damp_word;

        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        allow_gaps   = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a step from the all-zero chain stays put, then pull
        // toward both corners and re-place the chain between them.
        send_command(FUNC_STEP, COORD_MIN, COORD_MIN);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        send_command(FUNC_STEP, COORD_MIN, COORD_MIN);
        send_command(FUNC_INIT, COORD_MAX, COORD_MIN);
        send_command(FUNC_STEP, COORD_MIN, COORD_MAX);
        send_command(FUNC_STEP, COORD_MIN, COORD_MAX);
        send_command(FUNC_INIT, 12'hAAA, 12'h555);
        send_command(FUNC_STEP, 12'h555, 12'hAAA);
        settle_chain(CFG_PAUSE);

        // Single vertex with full gain and no damping loss.
        program_settings(16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_command(FUNC_INIT, COORD_MIN, COORD_MIN);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        send_command(FUNC_STEP, COORD_MIN, COORD_MIN);
        settle_chain(CFG_PAUSE);

        // Full chain, full gain: a square-wave target makes the tail ring up
        // toward the saturation limits.
        program_settings(16'd16, 16'hFFFF, 16'hFFFF, 1'b0);
        send_command(FUNC_INIT, COORD_MIN, COORD_MAX);
        for (k = 0; k < 8; k++)
        begin
            send_command(FUNC_STEP, (k % 2) ? COORD_MIN : COORD_MAX,
                         (k % 2) ? COORD_MAX : COORD_MIN);
        end
        settle_chain(CFG_PAUSE);

        // A count that masks to zero runs as one vertex; zero gain and zero
        // damping freeze the chain; the unused index must change nothing.
        program_settings(16'h0020, 16'h0000, 16'h0000, 1'b1);
        send_command(FUNC_STEP, 12'd100, 12'd200);
        send_command(FUNC_INIT, 12'd5, 12'd6);
        send_command(FUNC_STEP, COORD_MAX, COORD_MAX);
        settle_chain(CFG_PAUSE);

        // Random phases: each re-places the chain, then mostly steps it.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            square_wave = (phase == 2);
            if (phase == RANDOM_PHASES - 1)
            begin
                // drop all idling for the closing stretch
                allow_gaps = 1'b0;
            end
            case ($urandom_range(0, 7))
                0:       cnt = 5'd0;
                1:       cnt = CNT_CFG_W'($urandom_range(17, 31));
                default: cnt = CNT_CFG_W'($urandom_range(1, 16));
            endcase
            upper = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0;
            if (square_wave)
            begin
                cnt       = 5'd16;
                ease_word = FACT_W'($urandom_range(49152, 65535));
                damp_word = FACT_W'($urandom_range(60000, 65535));
            end
            else
            begin
                ease_word = pick_factor();
                damp_word = pick_factor();
            end
            program_settings({upper, cnt}, ease_word, damp_word, phase == 1);
            send_command(FUNC_INIT, pick_coord(), pick_coord());
            for (k = 1; k < PHASE_ITEMS; k++)
            begin
                if (square_wave)
                begin
                    send_command(FUNC_STEP, (k % 2) ? COORD_MAX : COORD_MIN, pick_coord());
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    send_command(FUNC_INIT, pick_coord(), pick_coord());
                end
                else
                begin
                    send_command(FUNC_STEP, pick_coord(), pick_coord());
                end
            end
            settle_chain((phase == RANDOM_PHASES - 1) ? END_PAUSE : CFG_PAUSE);
        end

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/sfc_pkg.sv
rtl/sfc_chan_if.sv
rtl/sfc_mul_unit.sv
rtl/spring_follower_chain.sv
tb/sv/chain_position_checker.sv
tb/sv/spring_follower_chain_test.sv
